>>> rtl/modexp_pkg.sv
// ---------------------------------------------------------------------------
// modexp_pkg
// Shared constants and controller/datapath interface types for the modular
// exponentiation block.
// ---------------------------------------------------------------------------
package modexp_pkg;

  // default widths of modulus/base and exponent
  localparam int unsigned MOD_WIDTH_DEFAULT = 31;
  localparam int unsigned EXP_WIDTH_DEFAULT = 63;

  // modulus after reset, truncated to the configured width where used
  localparam logic [63:0] MODULUS_RESET = 64'd1000000007;

  // commands from the controller to the datapath
  typedef struct packed {
    logic load;        // capture input beat
    logic start_base;  // reduce base modulo modulus
    logic init_loop;   // take reduced base as square, acc to one
    logic start_step;  // run multiply and square for one exponent bit
    logic step_update; // store products, shift exponent
    logic out_load;    // move accumulator to output register
  } ctrl_cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic in_special;  // input gives a fixed result (zero exponent or modulus)
    logic exp_last;    // no exponent bits left above the current one
    logic mul_done;    // multiply-reduce units have finished
  } ctrl_status_t;

endpackage

>>> rtl/modexp_mulmod.sv
// ---------------------------------------------------------------------------
// modexp_mulmod
// Bit-serial interleaved modular multiplier: x * y mod m, one bit of y per
// cycle from the top, with up to two conditional subtractions per cycle.
// ---------------------------------------------------------------------------
module modexp_mulmod #(
  parameter int unsigned MOD_WIDTH = modexp_pkg::MOD_WIDTH_DEFAULT
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [MOD_WIDTH-1:0] x_i,
  input  logic [MOD_WIDTH-1:0] y_i,
  input  logic [MOD_WIDTH-1:0] mod_i,
  output logic                 done_o,
  output logic [MOD_WIDTH-1:0] res_o
);
  import modexp_pkg::*;

  localparam int unsigned CntW = $clog2(MOD_WIDTH);
  localparam int unsigned SumW = MOD_WIDTH + 2;

  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic [CntW-1:0]      cnt_q, cnt_d;
  logic [MOD_WIDTH-1:0] x_q, x_d;
  logic [MOD_WIDTH-1:0] y_q, y_d;
  logic [MOD_WIDTH-1:0] r_q, r_d;

  logic [SumW-1:0] sum_w;
  logic [SumW-1:0] mod_ext;
  logic [SumW-1:0] red1;
  logic [SumW-1:0] red2;

  // double, add x on a set bit, bring back below m
  always_comb begin
    mod_ext = SumW'(mod_i);
    sum_w   = SumW'({r_q, 1'b0}) + (y_q[MOD_WIDTH-1] ? SumW'(x_q) : '0);
    red1    = (sum_w >= mod_ext) ? sum_w - mod_ext : sum_w;
    red2    = (red1 >= mod_ext) ? red1 - mod_ext : red1;
  end

  // iteration control
  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    x_d    = x_q;
    y_d    = y_q;
    r_d    = r_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CntW'(MOD_WIDTH - 1);
      x_d    = x_i;
      y_d    = y_i;
      r_d    = '0;
    end else if (busy_q) begin
      r_d = red2[MOD_WIDTH-1:0];
      y_d = {y_q[MOD_WIDTH-2:0], 1'b0};
      cnt_d = cnt_q - CntW'(1);
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_q <= cnt_d;
    x_q   <= x_d;
    y_q   <= y_d;
    r_q   <= r_d;
  end

  assign done_o = done_q;
  assign res_o  = r_q;

endmodule

>>> rtl/modexp_dp.sv
// ---------------------------------------------------------------------------
// modexp_dp
// Datapath: modulus register, operand registers, exponent shifter and the
// two multiply-reduce units (accumulator product and square).
// ---------------------------------------------------------------------------
module modexp_dp #(
  parameter int unsigned MOD_WIDTH = modexp_pkg::MOD_WIDTH_DEFAULT,
  parameter int unsigned EXP_WIDTH = modexp_pkg::EXP_WIDTH_DEFAULT,
  parameter int unsigned IN_BITS   = 96,
  parameter int unsigned OUT_BITS  = 32
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [MOD_WIDTH-1:0]     cfg_wdata_i,
  input  logic [IN_BITS-1:0]       in_data_i,
  output logic [OUT_BITS-1:0]      out_data_o,
  input  modexp_pkg::ctrl_cmd_t    cmd_i,
  output modexp_pkg::ctrl_status_t status_o
);
  import modexp_pkg::*;

  logic [MOD_WIDTH-1:0] modulus_q;
  logic [MOD_WIDTH-1:0] base_q;
  logic [EXP_WIDTH-1:0] exp_q;
  logic [MOD_WIDTH-1:0] acc_q;
  logic [MOD_WIDTH-1:0] sq_q;
  logic [MOD_WIDTH-1:0] res_q;

  logic [MOD_WIDTH-1:0] in_base;
  logic [EXP_WIDTH-1:0] in_exp;
  logic                 in_exp_zero;
  logic [MOD_WIDTH-1:0] one_mod;

  logic                 start_a;
  logic [MOD_WIDTH-1:0] x_a;
  logic [MOD_WIDTH-1:0] y_a;
  logic                 done_a;
  logic [MOD_WIDTH-1:0] res_a;
  logic                 start_b;
  logic [MOD_WIDTH-1:0] x_b;
  logic [MOD_WIDTH-1:0] y_b;
  logic                 done_b;
  logic [MOD_WIDTH-1:0] res_b;

  // input beat fields
  assign in_base     = in_data_i[MOD_WIDTH-1:0];
  assign in_exp      = in_data_i[MOD_WIDTH+EXP_WIDTH-1:MOD_WIDTH];
  assign in_exp_zero = (in_exp == '0);

  // one reduced modulo the modulus
  assign one_mod = {{(MOD_WIDTH-1){1'b0}}, (modulus_q != MOD_WIDTH'(1))};

  // modulus register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      modulus_q <= MODULUS_RESET[MOD_WIDTH-1:0];
    end else if (cfg_we_i) begin
      modulus_q <= cfg_wdata_i;
    end
  end

  // unit a: base reduction, then accumulator product
  assign start_a = cmd_i.start_base | cmd_i.start_step;
  assign x_a     = cmd_i.start_base ? one_mod : acc_q;
  assign y_a     = cmd_i.start_base ? base_q : sq_q;

  modexp_mulmod #(
    .MOD_WIDTH(MOD_WIDTH)
  ) u_mul_acc (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start_a),
    .x_i    (x_a),
    .y_i    (y_a),
    .mod_i  (modulus_q),
    .done_o (done_a),
    .res_o  (res_a)
  );

  // unit b: squaring; runs the base reduction alongside unit a so both finish together
  assign start_b = cmd_i.start_base | cmd_i.start_step;
  assign x_b     = cmd_i.start_base ? one_mod : sq_q;
  assign y_b     = cmd_i.start_base ? base_q : sq_q;

  modexp_mulmod #(
    .MOD_WIDTH(MOD_WIDTH)
  ) u_mul_sq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start_b),
    .x_i    (x_b),
    .y_i    (y_b),
    .mod_i  (modulus_q),
    .done_o (done_b),
    .res_o  (res_b)
  );

  // operand and result registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      base_q <= in_base;
      exp_q  <= in_exp;
      // fixed result: one for zero exponent, zero for zero modulus
      acc_q  <= {{(MOD_WIDTH-1){1'b0}}, in_exp_zero};
    end else if (cmd_i.init_loop) begin
      sq_q  <= res_a;
      acc_q <= one_mod;
    end else if (cmd_i.step_update) begin
      if (exp_q[0]) begin
        acc_q <= res_a;
      end
      sq_q  <= res_b;
      exp_q <= exp_q >> 1;
    end
    if (cmd_i.out_load) begin
      res_q <= acc_q;
    end
  end

  // status back to the controller
  assign status_o.in_special = in_exp_zero | (modulus_q == '0);
  assign status_o.exp_last   = ((exp_q >> 1) == '0);
  assign status_o.mul_done   = done_a & done_b;

  assign out_data_o = OUT_BITS'(res_q);

endmodule

>>> rtl/modexp_ctrl.sv
// ---------------------------------------------------------------------------
// modexp_ctrl
// Controller: sequences base reduction and the per-bit multiply/square
// steps, and owns the stream handshakes and the output valid flag.
// ---------------------------------------------------------------------------
module modexp_ctrl (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     s_axis_tvalid,
  output logic                     s_axis_tready,
  output logic                     m_axis_tvalid,
  input  logic                     m_axis_tready,
  output modexp_pkg::ctrl_cmd_t    cmd_o,
  input  modexp_pkg::ctrl_status_t status_i
);
  import modexp_pkg::*;

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_BASE_GO = 3'd1;
  localparam logic [2:0] S_BASE    = 3'd2;
  localparam logic [2:0] S_STEP_GO = 3'd3;
  localparam logic [2:0] S_STEP    = 3'd4;
  localparam logic [2:0] S_OUT     = 3'd5;

  logic [2:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;

  // sequencer
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid) begin
          cmd_o.load = 1'b1;
          state_d    = status_i.in_special ? S_OUT : S_BASE_GO;
        end
      end
      S_BASE_GO: begin
        cmd_o.start_base = 1'b1;
        state_d          = S_BASE;
      end
      S_BASE: begin
        if (status_i.mul_done) begin
          cmd_o.init_loop = 1'b1;
          state_d         = S_STEP_GO;
        end
      end
      S_STEP_GO: begin
        cmd_o.start_step = 1'b1;
        state_d          = S_STEP;
      end
      S_STEP: begin
        if (status_i.mul_done) begin
          cmd_o.step_update = 1'b1;
          state_d           = status_i.exp_last ? S_OUT : S_STEP_GO;
        end
      end
      S_OUT: begin
        if (!out_valid_q || m_axis_tready) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // output valid flag
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = out_valid_q;

endmodule

>>> rtl/modular_exponentiation.sv
// ---------------------------------------------------------------------------
// modular_exponentiation
// Square-and-multiply modular exponentiation with a configurable modulus.
// ---------------------------------------------------------------------------
// Usage:
//   The input stream carries one base and one exponent per beat; the output
//   stream returns base ** exponent mod modulus, one beat per input beat, in
//   order. The modulus is written through cfg_we_i / cfg_wdata_i while idle.
//   One item is processed at a time. An exponent of zero, or a modulus of
//   zero, gives a fixed result that goes straight to the output register.
//   Otherwise the base is reduced and then each exponent bit up to the
//   highest set one takes a pass through the bit-serial multiply-reduce
//   units, which run the multiply and the square side by side. The next
//   beat can be taken in the cycle after the result is loaded into the
//   output register, so the next item is taken while it waits; a stalled
//   receiver only holds back completion of the following item. Reset
//   clears the sequencer and the output valid flag and loads the modulus
//   with 1000000007 truncated.
// ---------------------------------------------------------------------------
module modular_exponentiation #(
  parameter int unsigned MOD_WIDTH = modexp_pkg::MOD_WIDTH_DEFAULT,
  parameter int unsigned EXP_WIDTH = modexp_pkg::EXP_WIDTH_DEFAULT,
  localparam int unsigned IN_BITS  = ((MOD_WIDTH + EXP_WIDTH + 7) / 8) * 8,
  localparam int unsigned OUT_BITS = ((MOD_WIDTH + 7) / 8) * 8
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [MOD_WIDTH-1:0] cfg_wdata_i,   // modulus
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [IN_BITS-1:0]   s_axis_tdata,  // base_value, exponent, zero pad
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [OUT_BITS-1:0]  m_axis_tdata   // power_result, zero pad
);
  import modexp_pkg::*;

  ctrl_cmd_t    cmd;
  ctrl_status_t status;

  modexp_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .cmd_o        (cmd),
    .status_i     (status)
  );

  modexp_dp #(
    .MOD_WIDTH(MOD_WIDTH),
    .EXP_WIDTH(EXP_WIDTH),
    .IN_BITS  (IN_BITS),
    .OUT_BITS (OUT_BITS)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_data_i  (s_axis_tdata),
    .out_data_o (m_axis_tdata),
    .cmd_i      (cmd),
    .status_o   (status)
  );

endmodule

>>> tb/testbench.sv
// ---------------------------------------------------------------------------
// testbench
// Self-checking bench for modular_exponentiation: directed edge cases and
// special moduli, then random base and exponent beats over several modulus
// settings, each beat checked against a typed power or a square-and-multiply
// predictor, with bursty input, a patterned output stall and a long hold-off.
// ---------------------------------------------------------------------------
module testbench;

  localparam int unsigned MW       = modexp_pkg::MOD_WIDTH_DEFAULT;
  localparam int unsigned EW       = modexp_pkg::EXP_WIDTH_DEFAULT;
  localparam int unsigned IN_BITS  = ((MW + EW + 7) / 8) * 8;
  localparam int unsigned OUT_BITS = ((MW + 7) / 8) * 8;

  localparam int unsigned NUM_DIRECTED   = 23;
  localparam int unsigned NUM_PHASES     = 8;
  localparam int unsigned PHASE_ITEMS    = 100;
  localparam int unsigned PRESSURE_ITEMS = 8;
  localparam int unsigned HOLD_CYCLES    = 600;
  localparam int unsigned TAIL_CYCLES    = 2200;

  localparam logic [MW-1:0] MOD_MAX   = {MW{1'b1}};
  localparam logic [EW-1:0] EXP_MAX   = {EW{1'b1}};
  localparam logic [MW-1:0] MOD_RESET = modexp_pkg::MODULUS_RESET[MW-1:0];

  // one accepted input beat and the power it must produce
  typedef struct packed {
    logic [MW-1:0] base;
    logic [EW-1:0] exponent;
    logic [MW-1:0] power;
  } power_job_t;

  // one directed row: optional modulus write, the beat, optional typed power
  typedef struct packed {
    logic          set_mod;
    logic [MW-1:0] modulus;
    logic [MW-1:0] base;
    logic [EW-1:0] exponent;
    logic          typed;
    logic [MW-1:0] power;
  } directed_vec_t;

  localparam directed_vec_t DIRECTED_VECS [NUM_DIRECTED] = '{
    // reset modulus 1000000007
    '{1'b0, 31'd0, 31'd0,          63'd0,  1'b1, 31'd1},
    '{1'b0, 31'd0, 31'd2,          63'd10, 1'b1, 31'd1024},
    '{1'b0, 31'd0, MOD_MAX,        63'd1,  1'b1, 31'd147483633},
    '{1'b0, 31'd0, 31'd1000000007, 63'd1,  1'b1, 31'd0},
    '{1'b0, 31'd0, 31'd1000000008, 63'd1,  1'b1, 31'd1},
    '{1'b0, 31'd0, 31'd0,          63'd5,  1'b1, 31'd0},
    '{1'b0, 31'd0, 31'd1,          EXP_MAX, 1'b1, 31'd1},
    '{1'b0, 31'd0, MOD_MAX,        EXP_MAX, 1'b0, 31'd0},
    // modulus zero: fixed results
    '{1'b1, 31'd0, 31'd9,          63'd0,  1'b1, 31'd1},
    '{1'b0, 31'd0, 31'd5,          63'd3,  1'b1, 31'd0},
    '{1'b0, 31'd0, MOD_MAX,        EXP_MAX, 1'b1, 31'd0},
    // modulus one: every residue is zero, but a zero exponent gives one
    '{1'b1, 31'd1, 31'd9,          63'd0,  1'b1, 31'd1},
    '{1'b0, 31'd0, 31'd7,          63'd1,  1'b1, 31'd0},
    '{1'b0, 31'd0, MOD_MAX,        EXP_MAX, 1'b1, 31'd0},
    // smallest intended modulus
    '{1'b1, 31'd2, 31'd3,          EXP_MAX, 1'b1, 31'd1},
    '{1'b0, 31'd0, 31'd2,          63'd1,  1'b1, 31'd0},
    '{1'b0, 31'd0, 31'd0,          63'd0,  1'b1, 31'd1},
    // largest modulus
    '{1'b1, MOD_MAX, MOD_MAX,      63'd1,  1'b1, 31'd0},
    '{1'b0, 31'd0, MOD_MAX - 31'd1, 63'd2, 1'b1, 31'd1},
    '{1'b0, 31'd0, MOD_MAX - 31'd1, EXP_MAX, 1'b1, MOD_MAX - 31'd1},
    '{1'b0, 31'd0, 31'd2,          63'd30, 1'b1, 31'd1073741824},
    '{1'b0, 31'd0, 31'd2,          63'd31, 1'b1, 31'd1},
    '{1'b0, 31'd0, 31'd3,          63'h4000_0000_0000_0000, 1'b0, 31'd0}
  };

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                cfg_we_i      = 1'b0;
  logic [MW-1:0]       cfg_wdata_i   = '0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [IN_BITS-1:0]  s_axis_tdata  = '0;  // base_value, exponent, zero pad
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OUT_BITS-1:0] m_axis_tdata;        // power_result, zero pad

  power_job_t    pending_powers [$];
  logic [MW-1:0] modulus_q = MOD_RESET;
  int unsigned   mismatches    = 0;
  int unsigned   items_sent    = 0;
  int unsigned   powers_seen   = 0;
  int unsigned   moduli_used   = 1;
  int unsigned   long_holds    = 0;
  bit            hold_req      = 1'b0;
  int unsigned   hold_left     = 0;
  int unsigned   rx_cycle      = 0;
  int unsigned   rx_mode       = 0;
  int unsigned   burst_left    = 0;

  modular_exponentiation DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // clock
  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // run limit
  initial begin
    #200_000_000;
    $display("FAIL modular_exponentiation");
    $finish;
  end

  // square-and-multiply over all exponent bits, every product reduced
  function automatic logic [MW-1:0] predict_power(input logic [MW-1:0] base,
                                                  input logic [EW-1:0] exponent,
                                                  input logic [MW-1:0] modulus);
    logic [63:0] acc;
    logic [63:0] sq;
    logic [63:0] m64;
    int          i;
    if (exponent == '0) return MW'(1);
    if (modulus == '0) return MW'(0);
    m64 = 64'(modulus);
    acc = 64'd1 % m64;
    sq  = 64'(base) % m64;
    for (i = 0; i < EW; i++) begin
      if (exponent[i]) acc = (acc * sq) % m64;
      sq = (sq * sq) % m64;
    end
    return acc[MW-1:0];
  endfunction

  task automatic report_mismatch(input string what);
    $display("ERROR %s", what);
    mismatches++;
  endtask

  // offer one beat and hold it until taken; the expected power is queued then
  task automatic offer_item(input logic [MW-1:0] base, input logic [EW-1:0] exponent,
                            input logic typed, input logic [MW-1:0] power);
    power_job_t job;
    job.base     = base;
    job.exponent = exponent;
    job.power    = typed ? power : predict_power(base, exponent, modulus_q);
    s_axis_tdata  <= IN_BITS'({exponent, base});
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    pending_powers.push_back(job);
    items_sent++;
  endtask

  // stop offering and wait for every queued power to come out
  task automatic wait_drain();
    s_axis_tvalid <= 1'b0;
    while (pending_powers.size() != 0) @(posedge clk_i);
  endtask

  task automatic set_modulus(input logic [MW-1:0] value);
    wait_drain();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i  <= 1'b0;
    modulus_q = value;
    moduli_used++;
  endtask

  // bases biased toward zero, one, the neighborhood of the modulus and the maximum
  function automatic logic [MW-1:0] pick_base(input logic [MW-1:0] modulus);
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return MW'(1);
      2:       return modulus - 1'b1;
      3:       return modulus;
      4:       return modulus + 1'b1;
      5:       return MOD_MAX;
      default: return MW'($urandom);
    endcase
  endfunction

  // exponents mostly short so the run stays quick, some full width
  function automatic logic [EW-1:0] pick_exponent(input int unsigned max_len);
    logic [63:0] raw;
    int unsigned len;
    raw = {$urandom, $urandom};
    case ($urandom_range(0, 15))
      0:       return '0;
      1, 2:    return raw[EW-1:0];
      3:       return EW'(64'd1 << $urandom_range(0, EW - 1));
      default: begin
        len = $urandom_range(1, max_len);
        raw = (raw & ((64'd1 << len) - 64'd1)) | (64'd1 << (len - 1));
        return raw[EW-1:0];
      end
    endcase
  endfunction

  // modulus for each random phase, extremes and special values included
  function automatic logic [MW-1:0] phase_modulus(input int unsigned phase);
    case (phase)
      0:       return MOD_MAX;
      1:       return MW'($urandom_range(2, 32'h7FFF_FFFF));
      2:       return MW'(2);
      3:       return MW'($urandom_range(3, 1000));
      4:       return MW'(1);
      5:       return MW'($urandom_range(2, 32'h3FFF_FFFF));
      6:       return '0;
      default: return MOD_RESET;
    endcase
  endfunction

  // output side: patterned stalls, long hold-off on request
  always @(posedge clk_i) begin
    rx_cycle++;
    if (rx_cycle % 100 == 0) rx_mode = $urandom_range(0, 3);
    if (hold_req) begin
      hold_req  = 1'b0;
      hold_left = HOLD_CYCLES;
      long_holds++;
    end
    if (hold_left != 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      case (rx_mode)
        0:       m_axis_tready <= 1'b1;
        1:       m_axis_tready <= 1'($urandom_range(0, 1));
        2:       m_axis_tready <= (rx_cycle % 4 == 0);
        default: m_axis_tready <= ($urandom_range(0, 7) != 0);
      endcase
    end
  end

  // compare each output beat with the oldest queued power
  always @(posedge clk_i) begin : check_powers
    power_job_t job;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      powers_seen++;
      if (pending_powers.size() == 0) begin
        report_mismatch($sformatf("unexpected output beat power=%0d",
                                  m_axis_tdata[MW-1:0]));
      end else begin
        job = pending_powers.pop_front();
        if (m_axis_tdata[MW-1:0] !== job.power)
          report_mismatch($sformatf("base=%0d exp=%0d: power %0d, want %0d",
                                    job.base, job.exponent,
                                    m_axis_tdata[MW-1:0], job.power));
      end
    end
  end

  // stimulus
  initial begin
    int unsigned   row;
    int unsigned   phase;
    int unsigned   n;
    int unsigned   gap;
    directed_vec_t vec;

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table
    for (row = 0; row < NUM_DIRECTED; row++) begin
      vec = DIRECTED_VECS[row];
      if (vec.set_mod) set_modulus(vec.modulus);
      offer_item(vec.base, vec.exponent, vec.typed, vec.power);
    end

    // random phases, one modulus each
    for (phase = 0; phase < NUM_PHASES; phase++) begin
      set_modulus(phase_modulus(phase));

      // fill the block while the output is held off
      if (phase == 0) begin
        hold_req = 1'b1;
        for (n = 0; n < PRESSURE_ITEMS; n++)
          offer_item(pick_base(modulus_q), pick_exponent(4), 1'b0, '0);
      end

      burst_left = 0;
      for (n = 0; n < PHASE_ITEMS; n++) begin
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 12);
          gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
          if (gap != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk_i);
          end
        end
        burst_left--;
        offer_item(pick_base(modulus_q), pick_exponent(12), 1'b0, '0);
      end
    end

    // wind down
    wait_drain();
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("covered %0d beats in %0d modulus settings, %0d results, %0d long stalls",
             items_sent, moduli_used, powers_seen, long_holds);
    $display("mismatches: %0d, results still queued: %0d",
             mismatches, pending_powers.size());
    if (mismatches == 0 && pending_powers.size() == 0) begin
      $display("PASS modular_exponentiation");
    end else begin
      $display("FAIL modular_exponentiation");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/modexp_pkg.sv
rtl/modexp_mulmod.sv
rtl/modexp_dp.sv
rtl/modexp_ctrl.sv
rtl/modular_exponentiation.sv
tb/testbench.sv
